// ===== rtl/image_sharpness_measure_core_assert.svh =====
// Assertion helpers, included by the RTL sequencer.
// Each macro expects clk and rst_n in the enclosing module.
`ifndef IMAGE_SHARPNESS_MEASURE_CORE_ASSERT_SVH
`define IMAGE_SHARPNESS_MEASURE_CORE_ASSERT_SVH

// Same-cycle implication
`define ISM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ism assertion failed");

// Next-cycle implication
`define ISM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ism assertion failed");

`endif

// ===== rtl/ism_pkg.sv =====
package ism_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int ACC_W     = 35;
  localparam int SUM_W     = 34;
  localparam int SHARP_W   = 18;
  localparam int RESP_W    = 12;
  localparam int DIV_W     = ACC_W + 6;   // sum * 64
  localparam int TAP_W     = 4;
  localparam int JOB_W     = 2;
  localparam int OUT_TDATA_W = 56;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // last tap of the 3x3 window
  localparam logic [TAP_W-1:0] TAP_LAST = 4'd8;

  // response jobs: bit 1 = current row (else previous), bit 0 = last column
  localparam logic [JOB_W-1:0] JOB_PREV_COL = 2'd0;
  localparam logic [JOB_W-1:0] JOB_PREV_END = 2'd1;
  localparam logic [JOB_W-1:0] JOB_CUR_COL  = 2'd2;
  localparam logic [JOB_W-1:0] JOB_CUR_END  = 2'd3;

  // window offsets: 0 = -1, 1 = 0, 2 = +1
  localparam logic [1:0] OFS_M1 = 2'd0;
  localparam logic [1:0] OFS_Z  = 2'd1;
  localparam logic [1:0] OFS_P1 = 2'd2;

  typedef struct packed {
    logic               pix_we;
    logic               rd_en;
    logic [TAP_W-1:0]   tap;
    logic [JOB_W-1:0]   job;
    logic               calc_en;
    logic               acc_en;
    logic               advance;
    logic               div_start;
    logic               out_load;
  } ism_cmd_t;

  typedef struct packed {
    logic r_ge1;
    logic c_ge1;
    logic r_last;
    logic c_last;
    logic div_done;
    logic out_full;
  } ism_sts_t;

  // window row offset of a tap
  function automatic logic [1:0] tap_row(logic [TAP_W-1:0] t);
    logic [1:0] k;
    case (t) inside
      4'd0, 4'd1, 4'd2: k = OFS_M1;
      4'd3, 4'd4, 4'd5: k = OFS_Z;
      default:          k = OFS_P1;
    endcase
    return k;
  endfunction

  // window column offset of a tap
  function automatic logic [1:0] tap_col(logic [TAP_W-1:0] t);
    logic [1:0] j;
    case (t) inside
      4'd0, 4'd3, 4'd6: j = OFS_M1;
      4'd1, 4'd4, 4'd7: j = OFS_Z;
      default:          j = OFS_P1;
    endcase
    return j;
  endfunction

endpackage

// ===== rtl/ism_div.sv =====
// Restoring divider, one quotient bit per cycle
module ism_div import ism_pkg::*; #(
  parameter int N = 41,
  parameter int D = 26
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [N-1:0]       dividend,
  input  logic [D-1:0]       divisor,
  output logic               done,
  output logic [SHARP_W-1:0] quotient
);

  localparam int CW = $clog2(N + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [N-1:0]  q_r;
  logic [D-1:0]  rem_r;
  logic [D-1:0]  dsr_r;
  logic [D:0]    rem_sh;
  logic [D:0]    diff;
  logic          ge;
  logic [D-1:0]  rem_nxt;
  logic [N-1:0]  q_nxt;

  // trial subtract
  always_comb begin
    rem_sh  = {rem_r, q_r[N-1]};
    diff    = rem_sh - {1'b0, dsr_r};
    ge      = ~diff[D];
    rem_nxt = ge ? diff[D-1:0] : rem_sh[D-1:0];
    q_nxt   = {q_r[N-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(N);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r[SHARP_W-1:0];

endmodule

// ===== rtl/ism_dp.sv =====
// Datapath: line stores, position, 3x3 window, filter, accumulator, output word
module ism_dp import ism_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [PIX_W-1:0]     pixel,
  input  ism_cmd_t             cmd,
  output ism_sts_t             sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [SHARP_W-1:0]   out_sharp,
  output logic [SUM_W-1:0]     out_sum
);

  localparam int DW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int AW    = $clog2(3 * MAX_WIDTH);
  localparam int PW    = DW + HW;
  localparam int WCMP  = (DW > CFG_W) ? DW : CFG_W;
  localparam int HCMP  = (HW > CFG_W) ? HW : CFG_W;
  localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  logic [DW-1:0]      w_r;
  logic [HW-1:0]      h_r;
  logic [DW-1:0]      col_r;
  logic [HW-1:0]      row_r;
  logic [1:0]         bank_r;
  logic [ACC_W-1:0]   acc_r;
  logic [RESP_W-1:0]  resp_r;
  logic [PW-1:0]      area_r;
  logic [PIX_W-1:0]   win_r [9];
  logic [PIX_W-1:0]   mem [3 * MAX_WIDTH];
  logic               out_valid_r;
  logic [SHARP_W-1:0] out_sharp_r;
  logic [SUM_W-1:0]   out_sum_r;

  logic [WCMP-1:0]    wd_w;
  logic [HCMP-1:0]    wd_h;
  logic [DW-1:0]      w_wr;
  logic [HW-1:0]      h_wr;
  logic               cfg_hit;
  logic               restart;
  logic [DW-1:0]      w_m1;
  logic [HW-1:0]      h_m1;
  logic [1:0]         k_ofs;
  logic [1:0]         j_ofs;
  logic [1:0]         rel;
  logic [1:0]         bank_sel;
  logic [DW-1:0]      x;
  logic [DW-1:0]      col_sel;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               div_done;
  logic [SHARP_W-1:0] quotient;
  logic signed [12:0] hd [3];
  logic signed [12:0] vd [3];
  logic signed [12:0] lx;
  logic signed [12:0] ly;
  logic [RESP_W-1:0]  resp;

  // clamp written dimensions to the supported range
  always_comb begin
    wd_w = WCMP'(cfg_wdata);
    wd_h = HCMP'(cfg_wdata);
    if (wd_w < WCMP'(2))              w_wr = DW'(2);
    else if (wd_w > WCMP'(MAX_WIDTH)) w_wr = DW'(MAX_WIDTH);
    else                              w_wr = DW'(wd_w);
    if (wd_h < HCMP'(2))               h_wr = HW'(2);
    else if (wd_h > HCMP'(MAX_HEIGHT)) h_wr = HW'(MAX_HEIGHT);
    else                               h_wr = HW'(wd_h);
  end

  assign cfg_hit = cfg_we && (cfg_addr == REG_IMAGE_WIDTH || cfg_addr == REG_IMAGE_HEIGHT);
  assign restart = cfg_hit || cmd.out_load;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= DW'(W_RST);
      h_r <= HW'(H_RST);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:  w_r <= w_wr;
        REG_IMAGE_HEIGHT: h_r <= h_wr;
        default: ;
      endcase
    end
  end

  // pixel count of a frame
  always_ff @(posedge clk) begin
    area_r <= PW'(w_r) * PW'(h_r);
  end

  assign w_m1 = w_r - DW'(1);
  assign h_m1 = h_r - HW'(1);

  // position in the frame; row bank is row number mod 3
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r  <= '0;
      row_r  <= '0;
      bank_r <= '0;
    end else if (cmd.advance) begin
      if (col_r == w_m1) begin
        col_r  <= '0;
        row_r  <= row_r + HW'(1);
        bank_r <= (bank_r == 2'd2) ? 2'd0 : bank_r + 2'd1;
      end else begin
        col_r <= col_r + DW'(1);
      end
    end
  end

  assign sts.r_ge1    = (row_r != '0);
  assign sts.c_ge1    = (col_r != '0);
  assign sts.r_last   = (row_r == h_m1);
  assign sts.c_last   = (col_r == w_m1);
  assign sts.div_done = div_done;
  assign sts.out_full = out_valid_r;

  // tap address with reflected borders
  always_comb begin
    k_ofs = tap_row(cmd.tap);
    j_ofs = tap_col(cmd.tap);
    // rel: 0 = current row, 1 = one row up, 2 = two rows up
    if (cmd.job[1]) begin
      case (k_ofs)
        OFS_M1:  rel = 2'd1;
        OFS_Z:   rel = 2'd0;
        default: rel = 2'd1;   // bottom border reflects onto the row above
      endcase
    end else begin
      case (k_ofs)
        OFS_M1:  rel = (row_r == HW'(1)) ? 2'd0 : 2'd2;  // top border reflects
        OFS_Z:   rel = 2'd1;
        default: rel = 2'd0;
      endcase
    end
    case (rel)
      2'd0:    bank_sel = bank_r;
      2'd1:    bank_sel = (bank_r == 2'd0) ? 2'd2 : bank_r - 2'd1;
      default: bank_sel = (bank_r == 2'd2) ? 2'd0 : bank_r + 2'd1;
    endcase
    x = cmd.job[0] ? w_m1 : col_r - DW'(1);
    case (j_ofs)
      OFS_M1:  col_sel = (x == '0) ? DW'(1) : x - DW'(1);
      OFS_Z:   col_sel = x;
      default: col_sel = (x == w_m1) ? w_r - DW'(2) : x + DW'(1);
    endcase
    rd_addr = AW'(bank_sel) * AW'(MAX_WIDTH) + AW'(col_sel);
    wr_addr = AW'(bank_r) * AW'(MAX_WIDTH) + AW'(col_r);
  end

  // line store write port
  always_ff @(posedge clk) begin
    if (cmd.pix_we) begin
      mem[wr_addr] <= pixel;
    end
  end

  // line store read port into the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (cmd.rd_en) begin
      win_r[cmd.tap] <= mem[rd_addr];
    end
  end

  // second differences across and down the window
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hd[i] = 13'sd2 * $signed({5'b0, win_r[3*i+1]}) - $signed({5'b0, win_r[3*i]})
              - $signed({5'b0, win_r[3*i+2]});
      vd[i] = 13'sd2 * $signed({5'b0, win_r[3+i]}) - $signed({5'b0, win_r[i]})
              - $signed({5'b0, win_r[6+i]});
    end
    lx = hd[0] + 13'sd2 * hd[1] + hd[2];
    ly = vd[0] + 13'sd2 * vd[1] + vd[2];
    resp = RESP_W'(lx[12] ? -lx : lx) + RESP_W'(ly[12] ? -ly : ly);
  end

  // response register and frame accumulator
  always_ff @(posedge clk) begin
    if (cmd.calc_en) begin
      resp_r <= resp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + ACC_W'(resp_r);
    end
  end

  // mean = sum * 64 / (w * h)
  ism_div #(.N(DIV_W), .D(PW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({acc_r, 6'b0}),
    .divisor  (area_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sharp_r <= quotient;
      out_sum_r   <= acc_r[SUM_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_sharp = out_sharp_r;
  assign out_sum   = out_sum_r;

endmodule

// ===== rtl/ism_ctrl.sv =====
`include "image_sharpness_measure_core_assert.svh"

// Sequencer: per pixel, runs the 3x3 window fetch and accumulate once per response due
module ism_ctrl import ism_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ism_sts_t sts,
  output ism_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_PICK, S_READ, S_CALC, S_ACC, S_STEP, S_DIV, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [3:0]       jobs_r, jobs_nxt;
  logic [JOB_W-1:0] job_r, job_nxt;
  logic [TAP_W-1:0] tap_r, tap_nxt;

  always_comb begin
    state_nxt = state_r;
    jobs_nxt  = jobs_r;
    job_nxt   = job_r;
    tap_nxt   = tap_r;
    cmd       = '0;
    cmd.tap   = tap_r;
    cmd.job   = job_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.pix_we = 1'b1;
          jobs_nxt   = {sts.r_last & sts.c_last, sts.r_last & sts.c_ge1,
                        sts.r_ge1 & sts.c_last, sts.r_ge1 & sts.c_ge1};
          state_nxt  = S_PICK;
        end
      end
      S_PICK: begin
        tap_nxt = '0;
        if (jobs_r[0]) begin
          job_nxt = JOB_PREV_COL; jobs_nxt[0] = 1'b0; state_nxt = S_READ;
        end else if (jobs_r[1]) begin
          job_nxt = JOB_PREV_END; jobs_nxt[1] = 1'b0; state_nxt = S_READ;
        end else if (jobs_r[2]) begin
          job_nxt = JOB_CUR_COL;  jobs_nxt[2] = 1'b0; state_nxt = S_READ;
        end else if (jobs_r[3]) begin
          job_nxt = JOB_CUR_END;  jobs_nxt[3] = 1'b0; state_nxt = S_READ;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        tap_nxt   = tap_r + TAP_W'(1);
        if (tap_r == TAP_LAST) state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc_en = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_PICK;
      end
      S_STEP: begin
        if (sts.r_last && sts.c_last) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      jobs_r  <= '0;
      job_r   <= JOB_PREV_COL;
      tap_r   <= '0;
    end else begin
      state_r <= state_nxt;
      jobs_r  <= jobs_nxt;
      job_r   <= job_nxt;
      tap_r   <= tap_nxt;
    end
  end

  `ISM_ASSERT_IMP(a_load_after_div, cmd.out_load, sts.div_done && !sts.out_full)
  `ISM_ASSERT_IMP(a_div_on_last_px, cmd.div_start, sts.r_last && sts.c_last)
  `ISM_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  `ISM_ASSERT_IMP(a_read_tap_range, cmd.rd_en, tap_r <= TAP_LAST)

endmodule

// ===== rtl/image_sharpness_measure_core.sv =====
// Modified-Laplacian focus measure over one grey frame in raster order. Each
// accepted pixel completes n (0 to 4) filter responses before the next pixel
// is taken: one inside the frame, two at a row end or on the last row, four at
// the final pixel. Every response reads its 3x3 window from the line store one
// pixel per cycle. After the final pixel a one-bit-per-cycle divider runs, then
// the result word is loaded once the previous result word has been taken;
// pixels are not taken meanwhile. Writing image_width or image_height restarts
// the frame and drops any partial sum.
module image_sharpness_measure_core import ism_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [PIX_W-1:0]       in_tdata,    // [7:0] pixel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [17:0] sharpness_q8, [51:18] response_sum
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  ism_cmd_t           cmd;
  ism_sts_t           sts;
  logic [SHARP_W-1:0] sharp;
  logic [SUM_W-1:0]   sum;

  ism_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ism_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .pixel     (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_sharp (sharp),
    .out_sum   (sum)
  );

  // pack result word, zero padded to whole bytes
  assign out_tdata = {(OUT_TDATA_W - SUM_W - SHARP_W)'(0), sum, sharp};

endmodule

// ===== sim/image_sharpness_measure_checker.sv =====
`timescale 1ns / 100ps

// Watches the pixel, result and register ports of the focus-measure core,
// predicts each frame result and compares it with what the core returns.
module image_sharpness_measure_checker import ism_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [PIX_W-1:0]       in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  output int                     fail_count,
  output int                     results_pending
);

  typedef struct {
    logic [SHARP_W-1:0] sharpness_q8;
    logic [SUM_W-1:0]   response_sum;
  } focus_result_t;

  focus_result_t  focus_expected_q[$];
  logic [7:0]     frame_pixels[$];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  function automatic int clamp_dim(int v, int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int mirror(int i, int n);
    if (i < 0) return -i;
    if (i >= n) return 2 * n - 2 - i;
    return i;
  endfunction

  function automatic int pix_at(int y, int x, int w, int h);
    return frame_pixels[mirror(y, h) * w + mirror(x, w)];
  endfunction

  // |4*Lx| + |4*Ly| at one position
  function automatic int laplace_abs(int y, int x, int w, int h);
    int lx;
    int ly;
    int wt;
    lx = 0;
    ly = 0;
    for (int k = -1; k <= 1; k++) begin
      wt = (k == 0) ? 2 : 1;
      lx += wt * (2 * pix_at(y + k, x, w, h) - pix_at(y + k, x - 1, w, h)
                  - pix_at(y + k, x + 1, w, h));
      ly += wt * (2 * pix_at(y, x + k, w, h) - pix_at(y - 1, x + k, w, h)
                  - pix_at(y + 1, x + k, w, h));
    end
    if (lx < 0) lx = -lx;
    if (ly < 0) ly = -ly;
    return lx + ly;
  endfunction

  function automatic focus_result_t frame_focus(int w, int h);
    focus_result_t r;
    longint acc;
    acc = 0;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        acc += laplace_abs(y, x, w, h);
    acc = acc & 64'h7_FFFF_FFFF;
    r.sharpness_q8 = SHARP_W'(((acc * 64) / (w * h)) & 64'h3FFFF);
    r.response_sum = acc[SUM_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    int w;
    int h;
    int errs;
    focus_result_t exp_r;
    if (!rst_n) begin
      width_reg       <= 12'd640;
      height_reg      <= 12'd480;
      frame_pixels.delete();
      focus_expected_q.delete();
      fail_count      <= 0;
      results_pending <= 0;
    end else begin
      errs = 0;
      // register write restarts the frame
      if (cfg_we) begin
        if (cfg_addr == REG_IMAGE_WIDTH) begin
          width_reg <= cfg_wdata;
          frame_pixels.delete();
        end else if (cfg_addr == REG_IMAGE_HEIGHT) begin
          height_reg <= cfg_wdata;
          frame_pixels.delete();
        end
      end
      // pixel word
      if (in_tvalid && in_tready) begin
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        frame_pixels.insert(frame_pixels.size(), in_tdata);
        if (frame_pixels.size() == w * h) begin
          focus_expected_q.insert(focus_expected_q.size(), frame_focus(w, h));
          frame_pixels.delete();
        end
      end
      // result word
      if (out_tvalid && out_tready) begin
        if (focus_expected_q.size() == 0) begin
          $error("unexpected result word %h", out_tdata);
          errs++;
        end else begin
          exp_r = focus_expected_q.pop_front();
          if (out_tdata[17:0] !== exp_r.sharpness_q8) begin
            $error("sharpness_q8: expected %0d, got %0d",
                   exp_r.sharpness_q8, out_tdata[17:0]);
            errs++;
          end
          if (out_tdata[51:18] !== exp_r.response_sum) begin
            $error("response_sum: expected %0d, got %0d",
                   exp_r.response_sum, out_tdata[51:18]);
            errs++;
          end
        end
      end
      fail_count      <= fail_count + errs;
      results_pending <= focus_expected_q.size();
    end
  end

endmodule

// ===== sim/image_sharpness_measure_core_tb.sv =====
`timescale 1ns / 100ps

module image_sharpness_measure_core_tb;
  import ism_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;
  localparam int SETTLE_CYCLES = 120;
  localparam int STALL_LIMIT   = 3000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [PIX_W-1:0]       in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_addr;
  logic [CFG_W-1:0]       cfg_wdata;
  int                     fail_count;
  int                     results_pending;
  int                     send_gap_max;
  int                     recv_gap_max;
  int                     recv_wait;
  int                     quiet_cycles;
  int                     random_pixels;

  image_sharpness_measure_core dut (.*);

  image_sharpness_measure_checker checker_i (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // result side: random stall before each word
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait  <= 0;
    end else if (out_tvalid && out_tready) begin
      recv_wait  <= $urandom_range(0, recv_gap_max);
      out_tready <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait  <= recv_wait - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [7:0] p);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // let every result drain and the core settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // pattern: 0 random, 1 all zero, 2 all ones, 3 checkerboard of extremes
  task automatic send_frame(input int w, input int h, input int pattern);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        case (pattern)
          1:       send_pixel(8'h00);
          2:       send_pixel(8'hFF);
          3:       send_pixel(((x + y) % 2) ? 8'hFF : 8'h00);
          default: send_pixel(8'($urandom_range(0, 255)));
        endcase
  endtask

  initial begin
    int w;
    int h;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    send_gap_max = 0;
    recv_gap_max = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: smallest frame, extreme pixel patterns
    write_reg(REG_IMAGE_WIDTH, 2);
    write_reg(REG_IMAGE_HEIGHT, 2);
    send_frame(2, 2, 1);
    send_frame(2, 2, 2);
    send_frame(2, 2, 3);
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 3);
    send_frame(3, 3, 3);
    send_frame(3, 3, 0);
    // register values below range clamp to two
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 1);
    send_frame(2, 2, 0);
    // unused register indexes do nothing
    write_reg(REG_UNUSED_2, 12'hFFF);
    write_reg(REG_UNUSED_3, 5);
    send_frame(2, 2, 0);
    // partial frame dropped by a register write
    send_pixel(8'hFF);
    send_pixel(8'h12);
    send_pixel(8'h80);
    write_reg(REG_IMAGE_WIDTH, 2);
    send_frame(2, 2, 3);

    // above-range values, partial frames dropped by the next write
    send_gap_max = 2;
    recv_gap_max = 16;
    write_reg(REG_IMAGE_WIDTH, 12'hFFF);
    repeat (20) send_pixel(8'($urandom_range(0, 255)));
    write_reg(REG_IMAGE_HEIGHT, 12'hFFF);
    repeat (20) send_pixel(8'($urandom_range(0, 255)));

    // random: small frames, varied idling
    random_pixels = 0;
    while (random_pixels < 540) begin
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
      recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 40) : $urandom_range(2, 6);
      h = $urandom_range(2, 6);
      if ($urandom_range(0, 9) == 0) begin
        write_reg(REG_IMAGE_WIDTH, $urandom_range(0, 1));
        w = 2;
      end else begin
        write_reg(REG_IMAGE_WIDTH, w);
      end
      write_reg(REG_IMAGE_HEIGHT, h);
      repeat ($urandom_range(1, 4)) begin
        send_frame(w, h, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
        random_pixels += w * h;
      end
      // occasional broken frame left for the next write to drop
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, w * h - 1)) send_pixel(8'($urandom_range(0, 255)));
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
